// ===== rtl/deploy_mode_supervisor_unit_macros.svh =====
// Assertion macros used by the checker file of the deploy mode supervisor.
`ifndef DEPLOY_MODE_SUPERVISOR_UNIT_MACROS_SVH
`define DEPLOY_MODE_SUPERVISOR_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define DMS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dms_pkg.sv =====
// Package: shared types, widths, mode codes and register defaults of the supervisor.
package dms_pkg;

  localparam int RATE_BITS = 16;
  localparam int SQ_W      = 2 * RATE_BITS;
  localparam int SUM_W     = SQ_W + 2;
  localparam int CMP_W     = (SUM_W > 32) ? SUM_W : 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 16;

  typedef enum logic [2:0] {
    MODE_BOOT       = 3'd0,
    MODE_DETUMBLE   = 3'd1,
    MODE_NOMINAL    = 3'd2,
    MODE_DIAGNOSTIC = 3'd3,
    MODE_SAFE       = 3'd4
  } mode_t;

  localparam logic [2:0] TARGET_NONE = 3'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOOT_SETTLE   = 3'd0,
    CFG_STABLE_THR    = 3'd1,
    CFG_HARD_RESET    = 3'd2,
    CFG_STABLE_NEEDED = 3'd3,
    CFG_BOOT_TIMEOUT  = 3'd4,
    CFG_DET_TIMEOUT   = 3'd5,
    CFG_DIAG_TIMEOUT  = 3'd6
  } cfg_reg_t;

  localparam logic [31:0]      RST_BOOT_SETTLE   = 32'd5000;
  localparam logic [31:0]      RST_STABLE_THR    = 32'd1000000;
  localparam logic [31:0]      RST_HARD_RESET    = 32'd4000000;
  localparam logic [CNT_W-1:0] RST_STABLE_NEEDED = 16'd10;
  localparam logic [31:0]      RST_BOOT_TIMEOUT  = 32'd60000;
  localparam logic [31:0]      RST_DET_TIMEOUT   = 32'd3600000;
  localparam logic [31:0]      RST_DIAG_TIMEOUT  = 32'd600000;

  // One monitor tick after capture; the rates are already squared.
  typedef struct packed {
    logic [2:0]      cur_mode;
    logic            selftest_present;
    logic            selftest_critical;
    logic            imu_ok;
    logic [31:0]     time_in_mode_ms;
    logic [SQ_W-1:0] sq_x;
    logic [SQ_W-1:0] sq_y;
    logic [SQ_W-1:0] sq_z;
    logic            auto_grant;
  } tick_t;

  typedef struct packed {
    logic             auto_request;
    logic [2:0]       auto_target;
    logic             timeout_request;
    logic [2:0]       timeout_target;
    logic             deploy_active;
    logic [CNT_W-1:0] stable_level;
  } result_t;

  // Square of a two's complement rate; the most negative code squares to 2^(2*RATE_BITS-2).
  function automatic logic [SQ_W-1:0] rate_sq(input logic [RATE_BITS-1:0] v);
    logic [RATE_BITS-1:0] mag;
    mag = v[RATE_BITS-1] ? RATE_BITS'(~v + 1'b1) : v;
    return SQ_W'(mag) * SQ_W'(mag);
  endfunction

endpackage

// ===== rtl/dms_in_stage.sv =====
// Input stage: capture one tick beat and square the three body rates.
module dms_in_stage
  import dms_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           cur_mode,
  input  logic                 selftest_present,
  input  logic                 selftest_critical,
  input  logic                 imu_ok,
  input  logic [31:0]          time_in_mode_ms,
  input  logic [RATE_BITS-1:0] rate_x,
  input  logic [RATE_BITS-1:0] rate_y,
  input  logic [RATE_BITS-1:0] rate_z,
  input  logic                 auto_grant,
  input  logic                 pop,
  output logic                 tick_valid,
  output tick_t                tick
);

  logic take;

  assign in_ready = !tick_valid || pop;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (take) begin
      tick_valid <= 1'b1;
    end else if (pop) begin
      tick_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tick.cur_mode          <= cur_mode;
      tick.selftest_present  <= selftest_present;
      tick.selftest_critical <= selftest_critical;
      tick.imu_ok            <= imu_ok;
      tick.time_in_mode_ms   <= time_in_mode_ms;
      tick.sq_x              <= rate_sq(rate_x);
      tick.sq_y              <= rate_sq(rate_y);
      tick.sq_z              <= rate_sq(rate_z);
      tick.auto_grant        <= auto_grant;
    end
  end

endmodule

// ===== rtl/dms_core.sv =====
// Core: configuration registers, deploy flag, stability counter and request logic.
module dms_core
  import dms_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 fire,
  input  tick_t                tick,
  output result_t              res
);

  logic [31:0]      boot_settle_ms;
  logic [31:0]      stable_threshold_sq;
  logic [31:0]      hard_reset_sq;
  logic [CNT_W-1:0] stable_needed;
  logic [31:0]      boot_timeout_ms;
  logic [31:0]      detumble_timeout_ms;
  logic [31:0]      diagnostic_timeout_ms;

  logic             deploy_flag;
  logic             deploy_flag_next;
  logic [CNT_W-1:0] stable_counter;
  logic [CNT_W-1:0] stable_counter_next;

  logic [SUM_W-1:0] rate_sum;
  logic [CMP_W-1:0] rate_cmp;
  logic             is_boot;
  logic             is_detumble;
  logic             is_diag;
  logic [CNT_W-1:0] cnt_leak;

  always_ff @(posedge clk) begin
    if (rst) begin
      boot_settle_ms        <= RST_BOOT_SETTLE;
      stable_threshold_sq   <= RST_STABLE_THR;
      hard_reset_sq         <= RST_HARD_RESET;
      stable_needed         <= RST_STABLE_NEEDED;
      boot_timeout_ms       <= RST_BOOT_TIMEOUT;
      detumble_timeout_ms   <= RST_DET_TIMEOUT;
      diagnostic_timeout_ms <= RST_DIAG_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOOT_SETTLE:   boot_settle_ms        <= cfg_data[31:0];
        CFG_STABLE_THR:    stable_threshold_sq   <= cfg_data[31:0];
        CFG_HARD_RESET:    hard_reset_sq         <= cfg_data[31:0];
        CFG_STABLE_NEEDED: stable_needed         <= cfg_data[CNT_W-1:0];
        CFG_BOOT_TIMEOUT:  boot_timeout_ms       <= cfg_data[31:0];
        CFG_DET_TIMEOUT:   detumble_timeout_ms   <= cfg_data[31:0];
        CFG_DIAG_TIMEOUT:  diagnostic_timeout_ms <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deploy_flag    <= 1'b0;
      stable_counter <= '0;
    end else if (fire) begin
      deploy_flag    <= deploy_flag_next;
      stable_counter <= stable_counter_next;
    end
  end

  always_comb begin
    rate_sum    = SUM_W'(tick.sq_x) + SUM_W'(tick.sq_y) + SUM_W'(tick.sq_z);
    rate_cmp    = CMP_W'(rate_sum);
    is_boot     = (tick.cur_mode == MODE_BOOT);
    is_detumble = (tick.cur_mode == MODE_DETUMBLE);
    is_diag     = (tick.cur_mode == MODE_DIAGNOSTIC);

    deploy_flag_next    = deploy_flag;
    stable_counter_next = stable_counter;
    res                 = '0;
    res.auto_target     = TARGET_NONE;
    res.timeout_target  = TARGET_NONE;

    // Boot: request detumble once the vehicle is healthy and settled.
    if (is_boot && !deploy_flag && tick.selftest_present && !tick.selftest_critical &&
        tick.imu_ok && (tick.time_in_mode_ms >= boot_settle_ms)) begin
      res.auto_request = 1'b1;
      res.auto_target  = MODE_DETUMBLE;
      if (tick.auto_grant) begin
        deploy_flag_next = 1'b1;
      end
    end

    // Detumble: leaky stability counter on the squared rate magnitude.
    if (stable_counter != '0) begin
      cnt_leak = stable_counter - 1'b1;
    end else begin
      cnt_leak = stable_counter;
    end
    if (is_detumble) begin
      if (rate_cmp < CMP_W'(stable_threshold_sq)) begin
        if (stable_counter < stable_needed) begin
          stable_counter_next = stable_counter + 1'b1;
        end
      end else if (rate_cmp > CMP_W'(hard_reset_sq)) begin
        stable_counter_next = '0;
      end else begin
        stable_counter_next = cnt_leak;
      end
      if (stable_counter_next >= stable_needed) begin
        res.auto_request = 1'b1;
        res.auto_target  = MODE_NOMINAL;
        if (tick.auto_grant) begin
          deploy_flag_next    = 1'b0;
          stable_counter_next = '0;
        end
      end
    end

    // Timeouts come last so a boot timeout drops a flag set in this tick.
    if (is_boot && (tick.time_in_mode_ms >= boot_timeout_ms)) begin
      res.timeout_request = 1'b1;
      res.timeout_target  = MODE_SAFE;
      deploy_flag_next    = 1'b0;
    end else if (is_detumble && (tick.time_in_mode_ms >= detumble_timeout_ms)) begin
      res.timeout_request = 1'b1;
      res.timeout_target  = MODE_SAFE;
      deploy_flag_next    = 1'b0;
    end else if (is_diag && (tick.time_in_mode_ms >= diagnostic_timeout_ms)) begin
      res.timeout_request = 1'b1;
      res.timeout_target  = MODE_NOMINAL;
    end

    res.deploy_active = deploy_flag_next;
    res.stable_level  = stable_counter_next;
  end

endmodule

// ===== rtl/dms_out_stage.sv =====
// Output stage: result register that holds a beat until the consumer takes it.
module dms_out_stage
  import dms_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  output logic    space,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t res_out
);

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ===== rtl/deploy_mode_supervisor_unit.sv =====
// Top level of the deploy mode supervisor: input stage, decision core, result register.
// Flow: a tick accepted into the input register enters the result register once that register
//   has room, and its result beat is offered from there until the consumer takes it.
// Throughput: one tick per cycle while the consumer takes each result; the input register advances
//   whenever the result register is empty or being drained in the same cycle.
// Reset (rst, synchronous, active high): clears both valid flags, the deploy flag
//   and the stability counter, and loads the registers with their default values.
module deploy_mode_supervisor_unit
  import dms_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  // configuration write port
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  // tick channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  cur_mode,
  input  logic                        selftest_present,
  input  logic                        selftest_critical,
  input  logic                        imu_ok,
  input  logic [31:0]                 time_in_mode_ms,
  input  logic signed [RATE_BITS-1:0] rate_x,
  input  logic signed [RATE_BITS-1:0] rate_y,
  input  logic signed [RATE_BITS-1:0] rate_z,
  input  logic                        auto_grant,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        auto_request,
  output logic [2:0]                  auto_target,
  output logic                        timeout_request,
  output logic [2:0]                  timeout_target,
  output logic                        deploy_active,
  output logic [CNT_W-1:0]            stable_level
);

  tick_t   tick;
  logic    tick_valid;
  logic    space;
  logic    fire;
  result_t res_next;
  result_t res;

  // Advance a held tick into the result register when there is room for its beat;
  // the core commits its state at the same edge, so the next tick sees it.
  assign fire = tick_valid && space;

  // Capture the tick beat and square the rates on the way in.
  dms_in_stage u_in (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .cur_mode          (cur_mode),
    .selftest_present  (selftest_present),
    .selftest_critical (selftest_critical),
    .imu_ok            (imu_ok),
    .time_in_mode_ms   (time_in_mode_ms),
    .rate_x            (rate_x),
    .rate_y            (rate_y),
    .rate_z            (rate_z),
    .auto_grant        (auto_grant),
    .pop               (fire),
    .tick_valid        (tick_valid),
    .tick              (tick)
  );

  // Sum, compare, update the counter and flag, and form both requests.
  dms_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .tick      (tick),
    .res       (res_next)
  );

  // Hold the result beat until the consumer takes it.
  dms_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res_in    (res_next),
    .space     (space),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_out   (res)
  );

  assign auto_request    = res.auto_request;
  assign auto_target     = res.auto_target;
  assign timeout_request = res.timeout_request;
  assign timeout_target  = res.timeout_target;
  assign deploy_active   = res.deploy_active;
  assign stable_level    = res.stable_level;

endmodule

// ===== rtl/dms_checker.sv =====
// Checker: port-level assertions on the supervisor, attached by bind.
`include "deploy_mode_supervisor_unit_macros.svh"

module dms_checker
  import dms_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic             auto_request,
  input logic [2:0]       auto_target,
  input logic             timeout_request,
  input logic [2:0]       timeout_target,
  input logic             deploy_active,
  input logic [CNT_W-1:0] stable_level
);

  // A stalled result beat holds still.
  `DMS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(auto_request) && $stable(auto_target) && $stable(timeout_request) && $stable(timeout_target) && $stable(deploy_active) && $stable(stable_level), "result beat changed while stalled")

  // No automatic request means no target.
  `DMS_ASSERT(a_auto_idle, out_valid && !auto_request |-> auto_target == TARGET_NONE, "auto target without request")

  // An automatic request goes to detumble or nominal only.
  `DMS_ASSERT(a_auto_tgt, out_valid && auto_request |-> auto_target == MODE_DETUMBLE || auto_target == MODE_NOMINAL, "bad auto target")

  // A fall to safe always drops the deploy flag.
  `DMS_ASSERT(a_safe_clear, out_valid && timeout_request && timeout_target == MODE_SAFE |-> !deploy_active, "deploy flag set after safe timeout")

  // Reset empties the result register.
  `DMS_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "result valid after reset")

endmodule

bind deploy_mode_supervisor_unit dms_checker u_dms_checker (.*);
